// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ITEM_WIDTH  = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ITEM_WIDTH-1:0] item_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic latch;
    logic compare;
    logic apply;
  } cmd_t;

endpackage

// File: rtl/spq_ctrl.sv
`timescale 1ns / 1ps
module spq_ctrl
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CMP;
        end
      end
      S_CMP:   state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    cmd  = '0;
    case (state)
      S_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      S_CMP:   cmd.compare = 1'b1;
      S_APPLY: cmd.apply   = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  a_apply_returns_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |=> state == S_IDLE)
    else $error("controller left apply without returning to idle");

  a_accept_starts_cmp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == S_CMP)
    else $error("accepted transfer did not enter compare");

endmodule

// File: rtl/spq_datapath.sv
`timescale 1ns / 1ps
module spq_datapath
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        mode,
  input  logic [15:0] item_in,
  input  logic [7:0]  type_in,
  input  logic [31:0] prio_in,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] item_out,
  output logic [7:0]  type_out,
  output logic [31:0] prio_out,
  output logic [6:0]  count
);

  logic [31:0] slot_prio [QUEUE_DEPTH];
  logic [7:0]  slot_type [QUEUE_DEPTH];
  item_t       slot_item [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] slot_valid;
  cnt_t occupancy;

  logic        req_mode;
  item_t       req_item;
  logic [7:0]  req_type;
  logic [31:0] req_prio;

  // after_flag: new entry goes at or before this slot (monotone over a sorted queue)
  logic [QUEUE_DEPTH-1:0] after_flag;
  logic [QUEUE_DEPTH-1:0] dup_flag;

  logic    dup_any;
  logic    full;
  logic    empty;
  logic    do_ins;
  logic    do_rem;
  status_t status_next;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_mode <= mode;
      req_item <= item_t'(item_in);
      req_type <= type_in;
      req_prio <= prio_in;
    end
  end

  assign dup_any = |dup_flag;
  assign full    = (occupancy == cnt_t'(QUEUE_DEPTH));
  assign empty   = (occupancy == '0);
  assign do_ins  = cmd.apply && (req_mode == MODE_INSERT) && !dup_any && !full;
  assign do_rem  = cmd.apply && (req_mode == MODE_REMOVE) && !empty;

  always_comb begin
    status_next = ST_OK;
    if (req_mode == MODE_REMOVE) begin
      if (empty) begin
        status_next = ST_EMPTY;
      end
    end else if (dup_any) begin
      status_next = ST_DUP;
    end else if (full) begin
      status_next = ST_FULL;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [31:0] prio_lo;
    logic [7:0]  type_lo;
    item_t       item_lo;
    logic        valid_lo;
    logic        after_lo;
    logic [31:0] prio_hi;
    logic [7:0]  type_hi;
    item_t       item_hi;
    logic        valid_hi;

    if (i == 0) begin : g_head
      assign prio_lo  = req_prio;
      assign type_lo  = req_type;
      assign item_lo  = req_item;
      assign valid_lo = 1'b1;
      assign after_lo = 1'b0;
    end else begin : g_mid_lo
      assign prio_lo  = slot_prio[i-1];
      assign type_lo  = slot_type[i-1];
      assign item_lo  = slot_item[i-1];
      assign valid_lo = slot_valid[i-1];
      assign after_lo = after_flag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign prio_hi  = '0;
      assign type_hi  = '0;
      assign item_hi  = '0;
      assign valid_hi = 1'b0;
    end else begin : g_mid_hi
      assign prio_hi  = slot_prio[i+1];
      assign type_hi  = slot_type[i+1];
      assign item_hi  = slot_item[i+1];
      assign valid_hi = slot_valid[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.compare) begin
        dup_flag[i]   <= slot_valid[i] && (slot_prio[i] == req_prio)
                         && (slot_type[i] == req_type);
        after_flag[i] <= !slot_valid[i] || (req_prio < slot_prio[i]);
      end
      if (do_ins && after_flag[i]) begin
        // shift down from the neighbor, or drop the new entry in at the boundary
        slot_prio[i] <= after_lo ? prio_lo : req_prio;
        slot_type[i] <= after_lo ? type_lo : req_type;
        slot_item[i] <= after_lo ? item_lo : req_item;
      end else if (do_rem) begin
        slot_prio[i] <= prio_hi;
        slot_type[i] <= type_hi;
        slot_item[i] <= item_hi;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        slot_valid[i] <= 1'b0;
      end else if (do_ins) begin
        slot_valid[i] <= slot_valid[i] || valid_lo;
      end else if (do_rem) begin
        slot_valid[i] <= valid_hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.apply;
      if (do_ins) begin
        occupancy <= occupancy + cnt_t'(1);
      end else if (do_rem) begin
        occupancy <= occupancy - cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status   <= status_next;
      item_out <= do_rem ? 16'(slot_item[0]) : '0;
      type_out <= do_rem ? slot_type[0] : '0;
      prio_out <= do_rem ? slot_prio[0] : '0;
      if (do_ins) begin
        count <= 7'(occupancy + cnt_t'(1));
      end else if (do_rem) begin
        count <= 7'(occupancy - cnt_t'(1));
      end else begin
        count <= 7'(occupancy);
      end
    end
  end

  a_valid_matches_occupancy: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == int'(occupancy))
    else $error("valid slots disagree with occupancy");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    int'(occupancy) <= QUEUE_DEPTH)
    else $error("occupancy above queue depth");

  a_empty_reports_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (count == '0 && prio_out == '0))
    else $error("empty result with nonzero count or data");

endmodule

// File: rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Channel   Handshake          Signals
// command   start / busy       mode, item_in, type_in, prio_in
// result    done (1 cycle)     status, item_out, type_out, prio_out, count
//
// A command transfers at an edge with start high and busy low; busy then stays
// high through compare (over all slots) and apply, then drops in idle, so a new
// command can transfer once apply ends. done pulses in the cycle after apply.
// rst is synchronous: the queue comes up empty, no slot contents are cleared.
// Receiver cannot stall; done is high one cycle, outputs hold until next apply.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [15:0] item_in,
  input  logic [7:0]  type_in,
  input  logic [31:0] prio_in,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] item_out,
  output logic [7:0]  type_out,
  output logic [31:0] prio_out,
  output logic [6:0]  count
);

  cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  spq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .mode     (mode),
    .item_in  (item_in),
    .type_in  (type_in),
    .prio_in  (prio_in),
    .done     (done),
    .status   (status),
    .item_out (item_out),
    .type_out (type_out),
    .prio_out (prio_out),
    .count    (count)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import spq_pkg::*;

  localparam int NUM_DIRECTED = 16;
  localparam int NUM_RANDOM   = 1500;
  localparam int PHASE_LEN    = 150;
  localparam int STALL_LIMIT  = 1000;

  typedef struct {
    mode_t       mode;
    logic [15:0] item;
    logic [7:0]  etype;
    logic [31:0] prio;
  } cmd_s;

  typedef struct {
    status_t     status;
    logic [15:0] item;
    logic [7:0]  etype;
    logic [31:0] prio;
    logic [6:0]  cnt;
  } outcome_s;

  typedef struct {
    cmd_s     cmd;
    bit       typed;
    outcome_s want;
  } dir_row_s;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        mode;
  logic [15:0] item_in;
  logic [7:0]  type_in;
  logic [31:0] prio_in;
  logic        done;
  logic [1:0]  status;
  logic [15:0] item_out;
  logic [7:0]  type_out;
  logic [31:0] prio_out;
  logic [6:0]  count;

  // Shadow copy of the sorted slots, head at index 0
  logic [31:0] shadow_prio [QUEUE_DEPTH];
  logic [7:0]  shadow_type [QUEUE_DEPTH];
  logic [15:0] shadow_item [QUEUE_DEPTH];
  int          shadow_occ;
  int          peak_occ;

  outcome_s queue_outcomes [$];
  int       mismatches;
  int       transfers;
  int       status_seen [4];
  int       idle_cycles;

  localparam outcome_s NONE = '{ST_OK, 16'h0, 8'h0, 32'h0, 7'd0};

  dir_row_s dir_rows [NUM_DIRECTED] = '{
    '{'{MODE_REMOVE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
      '{ST_EMPTY, 16'h0, 8'h0, 32'h0, 7'd0}},
    '{'{MODE_INSERT, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
      '{ST_OK, 16'h0, 8'h0, 32'h0, 7'd1}},
    '{'{MODE_INSERT, 16'h0000, 8'h00, 32'h0000_0000}, 1'b1,
      '{ST_OK, 16'h0, 8'h0, 32'h0, 7'd2}},
    '{'{MODE_INSERT, 16'h1234, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
      '{ST_DUP, 16'h0, 8'h0, 32'h0, 7'd2}},
    '{'{MODE_INSERT, 16'hAAAA, 8'h00, 32'hFFFF_FFFF}, 1'b1,
      '{ST_OK, 16'h0, 8'h0, 32'h0, 7'd3}},
    '{'{MODE_INSERT, 16'h5555, 8'h07, 32'h0000_0005}, 1'b0, NONE},
    '{'{MODE_INSERT, 16'h0001, 8'h08, 32'h0000_0005}, 1'b0, NONE},
    '{'{MODE_INSERT, 16'h8000, 8'h01, 32'h8000_0000}, 1'b0, NONE},
    '{'{MODE_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, 1'b1,
      '{ST_OK, 16'h0000, 8'h00, 32'h0000_0000, 7'd5}},
    '{'{MODE_REMOVE, 16'h00FF, 8'h0F, 32'h0F0F_0F0F}, 1'b0, NONE},
    '{'{MODE_REMOVE, 16'hFF00, 8'hF0, 32'hF0F0_F0F0}, 1'b0, NONE},
    '{'{MODE_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, 1'b0, NONE},
    '{'{MODE_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, 1'b1,
      '{ST_OK, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 7'd1}},
    '{'{MODE_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, 1'b1,
      '{ST_OK, 16'hAAAA, 8'h00, 32'hFFFF_FFFF, 7'd0}},
    '{'{MODE_REMOVE, 16'h0000, 8'h00, 32'h0000_0000}, 1'b1,
      '{ST_EMPTY, 16'h0, 8'h0, 32'h0, 7'd0}},
    '{'{MODE_INSERT, 16'h0FF0, 8'h80, 32'h7FFF_FFFF}, 1'b0, NONE}
  };

  sorted_priority_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .item_in  (item_in),
    .type_in  (type_in),
    .prio_in  (prio_in),
    .done     (done),
    .status   (status),
    .item_out (item_out),
    .type_out (type_out),
    .prio_out (prio_out),
    .count    (count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one command to the shadow queue and return what the block should report
  function automatic outcome_s predict_queue_op(cmd_s c);
    outcome_s r;
    bit       dup;
    int       pos;
    r   = NONE;
    dup = 1'b0;
    if (c.mode == MODE_INSERT) begin
      pos = shadow_occ;
      for (int i = 0; i < shadow_occ; i++) begin
        if (shadow_prio[i] == c.prio && shadow_type[i] == c.etype) dup = 1'b1;
        if (pos == shadow_occ && c.prio < shadow_prio[i]) pos = i;
      end
      if (dup) begin
        r.status = ST_DUP;
      end else if (shadow_occ >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (int i = shadow_occ; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_type[i] = shadow_type[i-1];
          shadow_item[i] = shadow_item[i-1];
        end
        shadow_prio[pos] = c.prio;
        shadow_type[pos] = c.etype;
        shadow_item[pos] = c.item;
        shadow_occ++;
        if (shadow_occ > peak_occ) peak_occ = shadow_occ;
      end
    end else if (shadow_occ == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.item  = shadow_item[0];
      r.etype = shadow_type[0];
      r.prio  = shadow_prio[0];
      for (int i = 0; i + 1 < shadow_occ; i++) begin
        shadow_prio[i] = shadow_prio[i+1];
        shadow_type[i] = shadow_type[i+1];
        shadow_item[i] = shadow_item[i+1];
      end
      shadow_occ--;
    end
    r.cnt = 7'(shadow_occ);
    return r;
  endfunction

  // Alternate fill-heavy and drain-heavy phases so the queue hits full and empty
  function automatic cmd_s random_cmd(int idx);
    cmd_s c;
    int   ins_pct;
    int   pick;
    int   k;
    ins_pct = ((idx / PHASE_LEN) % 2 == 0) ? 85 : 25;
    c.mode  = ($urandom_range(99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
    c.item  = 16'($urandom);
    c.etype = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    pick    = $urandom_range(9);
    if (pick < 4) c.prio = 32'($urandom_range(15));
    else if (pick == 4) c.prio = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    else c.prio = $urandom;
    // reuse a held key to force duplicates, more often once the queue is full
    if (c.mode == MODE_INSERT && shadow_occ > 0 &&
        $urandom_range(99) < ((shadow_occ == QUEUE_DEPTH) ? 40 : 12)) begin
      k       = $urandom_range(shadow_occ - 1);
      c.prio  = shadow_prio[k];
      c.etype = shadow_type[k];
    end
    return c;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    outcome_s want;
    if (!rst && done) begin
      if (queue_outcomes.size() == 0) begin
        $error("unexpected result: status %0d count %0d", status, count);
        mismatches++;
      end else begin
        want = queue_outcomes.pop_front();
        status_seen[want.status]++;
        check_field("status", 32'(want.status), 32'(status));
        check_field("item_out", 32'(want.item), 32'(item_out));
        check_field("type_out", 32'(want.etype), 32'(type_out));
        check_field("prio_out", want.prio, prio_out);
        check_field("count", 32'(want.cnt), 32'(count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    cmd_s     c;
    outcome_s o;
    bit       quiet;
    rst        <= 1'b1;
    start      <= 1'b0;
    mode       <= MODE_INSERT;
    item_in    <= '0;
    type_in    <= '0;
    prio_in    <= '0;
    shadow_occ  = 0;
    peak_occ    = 0;
    transfers   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < NUM_DIRECTED + NUM_RANDOM; n++) begin
      c = (n < NUM_DIRECTED) ? dir_rows[n].cmd : random_cmd(n - NUM_DIRECTED);
      quiet = (n >= 600 && n < 900);
      if (!quiet && $urandom_range(99) < 11) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      start   <= 1'b1;
      mode    <= c.mode;
      item_in <= c.item;
      type_in <= c.etype;
      prio_in <= c.prio;
      do @(posedge clk); while (busy);
      // transfer taken at this edge
      o = predict_queue_op(c);
      if (n < NUM_DIRECTED && dir_rows[n].typed) o = dir_rows[n].want;
      queue_outcomes.push_back(o);
      transfers++;
    end
    start <= 1'b0;

    while (queue_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d commands transferred (%0d directed), peak occupancy %0d of %0d",
             transfers, NUM_DIRECTED, peak_occ, QUEUE_DEPTH);
    $display("results checked: %0d ok, %0d duplicate, %0d full, %0d empty",
             status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_FULL],
             status_seen[ST_EMPTY]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
